[sv/fmr_pkg.sv]
// shared types, constants and the operation schedule of the formant resonator
package fmr_pkg;

    // accumulator width, products and sums wrap modulo 2^64
    localparam int ACC_W      = 64;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_COEF_A = 3'd1,
        REG_COEF_B = 3'd2,
        REG_COEF_C = 3'd3,
        REG_COEF_D = 3'd4
    } t_reg_idx;

    // filter modes
    typedef enum logic [1:0] {
        MODE_ALLPOLE = 2'd0,
        MODE_ANTI    = 2'd1,
        MODE_CGAIN   = 2'd2
    } t_mode;

    // input function codes
    typedef enum logic {
        FUNC_FILTER = 1'b0,
        FUNC_CLEAR  = 1'b1
    } t_func;

    // one step of the per-sample schedule
    typedef enum logic [2:0] {
        OP_AX,      // + a * x
        OP_BY1,     // + b * y1
        OP_CY2,     // + c * y2
        OP_BX1N,    // - b * x1
        OP_CX2N,    // - c * x2
        OP_DX2,     // + d * x2
        OP_INNER,   // round accumulator into inner term, clear accumulator
        OP_AI       // + a * inner
    } t_op_code;

    typedef struct packed {
        logic     last;
        t_op_code code;
    } t_op;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_FINAL
    } t_state;

    // command to the serial multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic preset;
        logic start;
        logic neg;
    } t_mac_cmd;

    // schedule of each mode, last marks the end of the list
    function automatic t_op op_at(input logic [1:0] mode, input logic [2:0] step);
        t_op op;
        op.last = 1'b1;
        op.code = OP_AX;
        case (t_mode'(mode))
            MODE_ANTI: begin
                case (step)
                    3'd0:    op = '{last: 1'b0, code: OP_BX1N};
                    3'd1:    op = '{last: 1'b0, code: OP_CX2N};
                    3'd2:    op = '{last: 1'b0, code: OP_INNER};
                    3'd3:    op = '{last: 1'b0, code: OP_AI};
                    default: op = '{last: 1'b1, code: OP_AX};
                endcase
            end
            MODE_CGAIN: begin
                case (step)
                    3'd0:    op = '{last: 1'b0, code: OP_DX2};
                    3'd1:    op = '{last: 1'b0, code: OP_INNER};
                    3'd2:    op = '{last: 1'b0, code: OP_AI};
                    3'd3:    op = '{last: 1'b0, code: OP_BY1};
                    3'd4:    op = '{last: 1'b0, code: OP_CY2};
                    default: op = '{last: 1'b1, code: OP_AX};
                endcase
            end
            default: begin
                // all-pole, also the unused mode code
                case (step)
                    3'd0:    op = '{last: 1'b0, code: OP_AX};
                    3'd1:    op = '{last: 1'b0, code: OP_BY1};
                    3'd2:    op = '{last: 1'b0, code: OP_CY2};
                    default: op = '{last: 1'b1, code: OP_AX};
                endcase
            end
        endcase
        return op;
    endfunction

endpackage

[sv/fmr_if.sv]
// valid/ready channel interfaces for input items and result items

interface fmr_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output func, output sample_in, input ready);
    modport sink   (input valid, input func, input sample_in, output ready);
endinterface

interface fmr_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

[sv/fmr_apb_regs.sv]
// apb configuration registers: filter mode and the four coefficients
module fmr_apb_regs #(
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fmr_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [fmr_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready,
    output logic [1:0]                            o_mode,
    output logic [COEF_FRAC_BITS+3:0]             o_coef_a,
    output logic [COEF_FRAC_BITS+3:0]             o_coef_b,
    output logic [COEF_FRAC_BITS+3:0]             o_coef_c,
    output logic [COEF_FRAC_BITS+3:0]             o_coef_d
);
    import fmr_pkg::*;

    localparam int COEF_W = COEF_FRAC_BITS + 4;
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

    logic [1:0]        r_mode;
    logic [COEF_W-1:0] r_coef_a;
    logic [COEF_W-1:0] r_coef_b;
    logic [COEF_W-1:0] r_coef_c;
    logic [COEF_W-1:0] r_coef_d;
    logic              wr_en;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // register writes, addresses beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ALLPOLE;
            r_coef_a <= COEF_ONE;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_coef_d <= '0;
        end else if (wr_en) begin
            case (t_reg_idx'(reg_idx))
                REG_MODE:   r_mode   <= pwdata[1:0];
                REG_COEF_A: r_coef_a <= pwdata[COEF_W-1:0];
                REG_COEF_B: r_coef_b <= pwdata[COEF_W-1:0];
                REG_COEF_C: r_coef_c <= pwdata[COEF_W-1:0];
                REG_COEF_D: r_coef_d <= pwdata[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (t_reg_idx'(reg_idx))
            REG_MODE:   prdata = CFG_DATA_W'(r_mode);
            REG_COEF_A: prdata = CFG_DATA_W'(r_coef_a);
            REG_COEF_B: prdata = CFG_DATA_W'(r_coef_b);
            REG_COEF_C: prdata = CFG_DATA_W'(r_coef_c);
            REG_COEF_D: prdata = CFG_DATA_W'(r_coef_d);
            default:    prdata = '0;
        endcase
    end

    assign o_mode   = r_mode;
    assign o_coef_a = r_coef_a;
    assign o_coef_b = r_coef_b;
    assign o_coef_c = r_coef_c;
    assign o_coef_d = r_coef_d;

endmodule

[sv/fmr_serial_mac.sv]
// bit-serial multiply-accumulate: one coefficient bit per cycle into a wide accumulator
module fmr_serial_mac #(
    parameter int COEF_W = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fmr_pkg::t_mac_cmd             i_cmd,
    input  logic [fmr_pkg::ACC_W-1:0]     i_preset,
    input  logic [COEF_W-1:0]             i_coef,
    input  logic [fmr_pkg::ACC_W-1:0]     i_operand,
    output logic                          o_busy,
    output logic [fmr_pkg::ACC_W-1:0]     o_acc
);
    import fmr_pkg::*;

    localparam int CNT_W = $clog2(COEF_W);

    logic              r_busy;
    logic              n_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [ACC_W-1:0]  r_mcand;
    logic [ACC_W-1:0]  n_mcand;
    logic [COEF_W-1:0] r_mplier;
    logic [COEF_W-1:0] n_mplier;
    logic              r_neg;
    logic              n_neg;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic              last_bit;
    logic              do_sub;
    logic [ACC_W-1:0]  addend;
    logic [ACC_W-1:0]  acc_sum;

    // the coefficient's top bit weighs negative, a negated product flips the sign again
    assign last_bit = (r_cnt == CNT_W'(COEF_W - 1));
    assign do_sub   = r_neg ^ last_bit;
    assign addend   = r_mplier[0] ? r_mcand : '0;
    assign acc_sum  = do_sub ? (r_acc - addend) : (r_acc + addend);

    // next values
    always_comb begin
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_neg    = r_neg;
        n_acc    = r_acc;
        if (i_cmd.clear) begin
            n_acc = '0;
        end else if (i_cmd.preset) begin
            n_acc = i_preset;
        end else if (r_busy) begin
            n_acc = acc_sum;
        end
        if (i_cmd.start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_mcand  = i_operand;
            n_mplier = i_coef;
            n_neg    = i_cmd.neg;
        end else if (r_busy) begin
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + CNT_W'(1);
            if (last_bit) begin
                n_busy = 1'b0;
            end
        end
    end

    // control flops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // datapath flops
    always_ff @(posedge i_clk) begin
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;

endmodule

[sv/formant_resonator_filter.sv]
// top level of the second-order formant resonator: sequencer, history and result register
//
// Channels: i_in carries one item per transfer (func, sample_in); func clears all four
// history samples and yields a zero result, otherwise sample_in is filtered in the mode
// held by the filter_mode register. o_out carries one result (sample_out, saturated) per
// item. Coefficients and mode are written over the apb port at byte address 4*index;
// the user must write them only while no item is in flight, which the block does not
// enforce; pready is always high.
// Timing: every product goes through one shared bit-serial multiplier that takes one
// coefficient bit per cycle. All-pole sums a*x, b*y1 and c*y2; anti-resonator scales
// the rounded x - b*x1 - c*x2 by a; constant-gain adds a times the rounded x + d*x2 to
// b*y1 and c*y2; a clear skips the products. The next input is taken in the cycle after
// the result is registered, so one item is in work at a time.
// Reset: synchronous, active low; history goes to zero, coef_a to unity, the rest to 0.
// Stall: the result register holds one finished result; a new item may be accepted and
// worked on meanwhile, and its result waits in the final step until the slot is free.
module formant_resonator_filter #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fmr_in_if.sink                            i_in,
    fmr_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fmr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fmr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import fmr_pkg::*;

    localparam int COEF_W = COEF_FRAC_BITS + 4;
    localparam logic [ACC_W-1:0] HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0] Y_MAX = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic [ACC_W-1:0] Y_MIN = ~Y_MAX;

    function automatic logic [ACC_W-1:0] sx(input logic [SAMPLE_WIDTH-1:0] v);
        return {{(ACC_W - SAMPLE_WIDTH){v[SAMPLE_WIDTH-1]}}, v};
    endfunction

    // configuration
    logic [1:0]        cfg_mode;
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [COEF_W-1:0] coef_c;
    logic [COEF_W-1:0] coef_d;

    fmr_apb_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_mode   (cfg_mode),
        .o_coef_a (coef_a),
        .o_coef_b (coef_b),
        .o_coef_c (coef_c),
        .o_coef_d (coef_d)
    );

    // sequencer and datapath registers
    t_state                   r_state;
    t_state                   n_state;
    logic [2:0]               r_step;
    logic [2:0]               n_step;
    logic                     r_clr;
    logic [SAMPLE_WIDTH-1:0]  r_x;
    logic [SAMPLE_WIDTH-1:0]  r_x1;
    logic [SAMPLE_WIDTH-1:0]  r_x2;
    logic [SAMPLE_WIDTH-1:0]  r_y1;
    logic [SAMPLE_WIDTH-1:0]  r_y2;
    logic [ACC_W-1:0]         r_inner;
    logic                     r_out_valid;
    logic [SAMPLE_WIDTH-1:0]  r_out_sample;
    logic                     r_out_sat;

    // control
    t_mac_cmd          mac_cmd;
    logic              mac_busy;
    logic [ACC_W-1:0]  mac_acc;
    logic [ACC_W-1:0]  mac_preset;
    logic [COEF_W-1:0] mac_coef;
    logic [ACC_W-1:0]  mac_operand;
    t_op               cur_op;
    logic              in_xfer;
    logic              out_xfer;
    logic              out_free;
    logic              inner_ld;
    logic              out_ld;

    // rounding and saturation of the accumulator
    logic [ACC_W-1:0]         acc_rnd;
    logic                     y_hi;
    logic                     y_lo;
    logic [SAMPLE_WIDTH-1:0]  y_sat;

    assign acc_rnd = ACC_W'($signed(mac_acc + HALF) >>> COEF_FRAC_BITS);
    assign y_hi    = $signed(acc_rnd) > $signed(Y_MAX);
    assign y_lo    = $signed(acc_rnd) < $signed(Y_MIN);
    assign y_sat   = y_hi ? Y_MAX[SAMPLE_WIDTH-1:0] :
                     y_lo ? Y_MIN[SAMPLE_WIDTH-1:0] : acc_rnd[SAMPLE_WIDTH-1:0];

    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign cur_op     = op_at(cfg_mode, r_step);
    assign mac_preset = sx(i_in.sample_in) << COEF_FRAC_BITS;

    // operand and coefficient for the current step
    always_comb begin
        case (cur_op.code)
            OP_AX:   begin mac_coef = coef_a; mac_operand = sx(r_x);  end
            OP_BY1:  begin mac_coef = coef_b; mac_operand = sx(r_y1); end
            OP_CY2:  begin mac_coef = coef_c; mac_operand = sx(r_y2); end
            OP_BX1N: begin mac_coef = coef_b; mac_operand = sx(r_x1); end
            OP_CX2N: begin mac_coef = coef_c; mac_operand = sx(r_x2); end
            OP_DX2:  begin mac_coef = coef_d; mac_operand = sx(r_x2); end
            OP_AI:   begin mac_coef = coef_a; mac_operand = r_inner;  end
            default: begin mac_coef = coef_a; mac_operand = r_inner;  end
        endcase
    end

    // next state and control outputs
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        mac_cmd       = '0;
        inner_ld      = 1'b0;
        out_ld        = 1'b0;
        i_in.ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_step = '0;
                    if (i_in.func == FUNC_CLEAR) begin
                        n_state = ST_FINAL;
                    end else begin
                        n_state = ST_STEP;
                        // the bracketed modes start from the input sample
                        if (cfg_mode == MODE_ANTI || cfg_mode == MODE_CGAIN) begin
                            mac_cmd.preset = 1'b1;
                        end else begin
                            mac_cmd.clear = 1'b1;
                        end
                    end
                end
            end
            ST_STEP: begin
                if (cur_op.last) begin
                    n_state = ST_FINAL;
                end else if (cur_op.code == OP_INNER) begin
                    inner_ld      = 1'b1;
                    mac_cmd.clear = 1'b1;
                    n_step        = r_step + 3'd1;
                end else begin
                    mac_cmd.start = 1'b1;
                    mac_cmd.neg   = (cur_op.code == OP_BX1N) || (cur_op.code == OP_CX2N);
                    n_step        = r_step + 3'd1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!mac_busy) begin
                    n_state = ST_STEP;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_ld  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    fmr_serial_mac #(
        .COEF_W (COEF_W)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mac_cmd),
        .i_preset  (mac_preset),
        .i_coef    (mac_coef),
        .i_operand (mac_operand),
        .o_busy    (mac_busy),
        .o_acc     (mac_acc)
    );

    // state, history and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_clr       <= 1'b0;
            r_x1        <= '0;
            r_x2        <= '0;
            r_y1        <= '0;
            r_y2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (in_xfer) begin
                r_clr <= (i_in.func == FUNC_CLEAR);
                if (i_in.func == FUNC_CLEAR) begin
                    r_x1 <= '0;
                    r_x2 <= '0;
                    r_y1 <= '0;
                    r_y2 <= '0;
                end
            end
            if (out_ld && !r_clr) begin
                r_x1 <= r_x;
                r_x2 <= r_x1;
                r_y1 <= y_sat;
                r_y2 <= r_y1;
            end
            if (out_ld) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= i_in.sample_in;
        end
        if (inner_ld) begin
            r_inner <= acc_rnd;
        end
        if (out_ld) begin
            r_out_sample <= r_clr ? '0 : y_sat;
            r_out_sat    <= r_clr ? 1'b0 : (y_hi || y_lo);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.saturated  = r_out_sat;

    // a saturated result sits at one of the range limits
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sat |->
            (r_out_sample == Y_MAX[SAMPLE_WIDTH-1:0]) ||
            (r_out_sample == Y_MIN[SAMPLE_WIDTH-1:0]))
        else $error("saturated flag with a sample inside the range");

    // the multiplier is never running while the block waits for input
    a_idle_mac_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !mac_busy)
        else $error("multiplier busy in idle state");

    // the sequencer stays waiting on the multiplier only while it is busy now or was busy in the cycle before
    a_mul_tracks_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL && $past(r_state) == ST_MUL |-> mac_busy || $past(mac_busy))
        else $error("sequencer stuck waiting on the multiplier");

    // a result only appears out of the final step
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_FINAL)
        else $error("result registered outside the final step");

endmodule

[dv/formant_resonator_filter_checker.sv]
// result predictor and comparator for the formant resonator, fed by the channels and the apb port
`timescale 1ns / 1ps

module formant_resonator_filter_checker #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_in_func,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_in_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_out_sample,
    input  logic                                i_out_saturated,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [fmr_pkg::CFG_ADDR_W-1:0]      i_paddr,
    input  logic [fmr_pkg::CFG_DATA_W-1:0]      i_pwdata,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import fmr_pkg::*;

    localparam int COEF_W      = COEF_FRAC_BITS + 4;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           saturated;
    } t_filtered;

    // filtered samples still owed by the block, oldest first
    t_filtered  filtered_q[$];
    t_filtered  due;
    logic [1:0] mode_reg;
    longint     gain_a, lag_b, lag_c, lag_d;
    longint     out_hist_1, out_hist_2, in_hist_1, in_hist_2;
    int         fails = 0;

    // add half an lsb, then drop the coefficient fraction bits
    function automatic longint round_to_sample(input longint acc);
        return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    endfunction

    // one filtered sample in the current mode, shifting both histories
    function automatic t_filtered resonate(input logic signed [SAMPLE_WIDTH-1:0] x_in);
        longint    x, inner, acc, y, hi, lo;
        t_filtered res;
        x  = longint'(x_in);
        hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        lo = -hi - 1;
        case (t_mode'(mode_reg))
            MODE_ANTI: begin
                inner = round_to_sample((x <<< COEF_FRAC_BITS) - lag_b * in_hist_1
                                        - lag_c * in_hist_2);
                acc   = gain_a * inner;
            end
            MODE_CGAIN: begin
                inner = round_to_sample((x <<< COEF_FRAC_BITS) + lag_d * in_hist_2);
                acc   = gain_a * inner + lag_b * out_hist_1 + lag_c * out_hist_2;
            end
            // the unused mode code falls here too
            default: acc = gain_a * x + lag_b * out_hist_1 + lag_c * out_hist_2;
        endcase
        y = round_to_sample(acc);
        res.saturated = 1'b0;
        if (y > hi) begin
            y = hi;
            res.saturated = 1'b1;
        end else if (y < lo) begin
            y = lo;
            res.saturated = 1'b1;
        end
        res.sample = SAMPLE_WIDTH'(y);
        out_hist_2 = out_hist_1;
        out_hist_1 = y;
        in_hist_2  = in_hist_1;
        in_hist_1  = x;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_reg   = MODE_ALLPOLE;
            gain_a     = longint'(1) <<< COEF_FRAC_BITS;
            lag_b      = 0;
            lag_c      = 0;
            lag_d      = 0;
            out_hist_1 = 0;
            out_hist_2 = 0;
            in_hist_1  = 0;
            in_hist_2  = 0;
            filtered_q.delete();
        end else begin
            // register write, indexes past the last register are dropped
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:2])
                    REG_MODE:   mode_reg = i_pwdata[1:0];
                    REG_COEF_A: gain_a   = longint'($signed(i_pwdata[COEF_W-1:0]));
                    REG_COEF_B: lag_b    = longint'($signed(i_pwdata[COEF_W-1:0]));
                    REG_COEF_C: lag_c    = longint'($signed(i_pwdata[COEF_W-1:0]));
                    REG_COEF_D: lag_d    = longint'($signed(i_pwdata[COEF_W-1:0]));
                    default: ;
                endcase
            end

            // result transfer against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: unexpected result sample %0d saturated %0b",
                                 $realtime, i_out_sample, i_out_saturated);
                    fails++;
                end else begin
                    due = filtered_q.pop_front();
                    if (due.sample !== i_out_sample || due.saturated !== i_out_saturated) begin
                        if (fails < MAX_REPORTS)
                            $display("%0t: result mismatch, expected sample %0d saturated %0b,",
                                     $realtime, due.sample, due.saturated,
                                     " got sample %0d saturated %0b",
                                     i_out_sample, i_out_saturated);
                        fails++;
                    end
                end
            end

            // input transfer: clear wipes history and yields zero
            if (i_in_valid && i_in_ready) begin
                if (i_in_func == FUNC_CLEAR) begin
                    out_hist_1 = 0;
                    out_hist_2 = 0;
                    in_hist_1  = 0;
                    in_hist_2  = 0;
                    filtered_q.push_back('{sample: '0, saturated: 1'b0});
                end else begin
                    filtered_q.push_back(resonate(i_in_sample));
                end
            end
        end
        o_pending    <= filtered_q.size();
        o_fail_count <= fails;
    end

endmodule

[dv/formant_resonator_filter_tb.sv]
// top of the formant resonator testbench: clock, reset, stimulus, configuration and verdict
`timescale 1ns / 1ps

module formant_resonator_filter_tb;
    import fmr_pkg::*;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 20;
    localparam int COEF_W         = COEF_FRAC_BITS + 4;
    localparam int SEL_W          = CFG_ADDR_W - 2;
    localparam int NUM_REGS       = 5;
    localparam int REG_SLOTS      = 1 << SEL_W;
    localparam int ITEM_TARGET    = 1700;
    localparam int DRAIN_CYCLES   = 150;
    localparam int TIMEOUT_NS     = 60_000_000;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]       COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]       COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]       COEF_ONE   = COEF_W'(1 << COEF_FRAC_BITS);

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_CHOKE
    } t_rx_style;

    typedef enum logic [1:0] {
        CFG_FORMANT,
        CFG_WILD,
        CFG_EDGE
    } t_cfg_style;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    pending;
    int                    fail_count;
    int                    items_sent;

    t_rx_style             rx_style = RX_OPEN;
    int                    rx_left  = 0;
    int                    rx_hold  = 0;

    fmr_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) in_ch ();
    fmr_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) out_ch ();

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    formant_resonator_filter #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    formant_resonator_filter_checker #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_func       (in_ch.func),
        .i_in_sample     (in_ch.sample_in),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_out_sample    (out_ch.sample_out),
        .i_out_saturated (out_ch.saturated),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // receiver: segments of free flow, coin-flip stalls and long chokes
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_style <= t_rx_style'($urandom_range(RX_OPEN, RX_CHOKE));
            rx_left  <= $urandom_range(40, 400);
        end else begin
            rx_left  <= rx_left - 1;
        end
        case (rx_style)
            RX_OPEN: out_ch.ready <= 1'b1;
            RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold > 0) begin
                    out_ch.ready <= 1'b0;
                    rx_hold      <= rx_hold - 1;
                end else if ($urandom_range(0, 15) == 0) begin
                    out_ch.ready <= 1'b0;
                    rx_hold      <= $urandom_range(20, 100);
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    // present one item and hold it until the transfer
    task automatic send_item(input t_func func, input logic signed [SAMPLE_WIDTH-1:0] sample);
        in_ch.valid     <= 1'b1;
        in_ch.func      <= func;
        in_ch.sample_in <= sample;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // stop sending and let every owed result come out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // apb write: setup, access, then idle with psel low
    task automatic write_reg(input logic [SEL_W-1:0] sel, input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // coefficient in the low bits, junk above
    function automatic logic [CFG_DATA_W-1:0] coef_word(input logic signed [COEF_W-1:0] coef);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom;
        word[COEF_W-1:0] = coef;
        return word;
    endfunction

    task automatic load_filter(input logic [1:0] mode, input logic signed [COEF_W-1:0] a,
                               input logic signed [COEF_W-1:0] b,
                               input logic signed [COEF_W-1:0] c,
                               input logic signed [COEF_W-1:0] d);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word      = $urandom;
        mode_word[1:0] = mode;
        write_reg(REG_MODE, mode_word);
        write_reg(REG_COEF_A, coef_word(a));
        write_reg(REG_COEF_B, coef_word(b));
        write_reg(REG_COEF_C, coef_word(c));
        write_reg(REG_COEF_D, coef_word(d));
    endtask

    // real value to q4.20, clipped to the register range
    function automatic logic signed [COEF_W-1:0] to_coef(input real value);
        real scaled;
        real lim;
        scaled = value * (2.0 ** COEF_FRAC_BITS);
        lim    = 2.0 ** (COEF_W - 1);
        if (scaled >= lim)
            return COEF_MAX;
        if (scaled < -lim)
            return COEF_MIN;
        return COEF_W'(longint'(scaled));
    endfunction

    function automatic logic signed [COEF_W-1:0] edge_coef();
        case ($urandom_range(0, 5))
            0:       return COEF_MIN;
            1:       return COEF_MAX;
            2:       return '0;
            3:       return COEF_ONE;
            4:       return -COEF_ONE;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // mostly a stable formant from pole radius and angle, else wild or corner coefficients
    task automatic random_filter(output int amp);
        t_cfg_style          style;
        logic [1:0]          mode;
        real                 radius, angle, b, c, a;
        logic signed [COEF_W-1:0] ca, cb, cc, cd;
        if ($urandom_range(0, 9) < 6)
            style = CFG_FORMANT;
        else
            style = $urandom_range(0, 1) ? CFG_WILD : CFG_EDGE;
        mode = 2'($urandom_range(MODE_ALLPOLE, MODE_UNUSED));
        case (style)
            CFG_FORMANT: begin
                radius = 0.5 + 0.499 * $urandom_range(0, 1000) / 1000.0;
                angle  = 3.14159265 * $urandom_range(1, 999) / 1000.0;
                b      = 2.0 * radius * $cos(angle);
                c      = -radius * radius;
                // anti-resonator gain is the inverse of the resonator gain
                a      = (mode == MODE_ANTI) ? 1.0 / (1.0 - b - c) : 1.0 - b - c;
                ca     = to_coef(a);
                cb     = to_coef(b);
                cc     = to_coef(c);
                cd     = ($urandom_range(0, 3) == 0) ? COEF_W'($urandom) : -COEF_ONE;
                amp    = $urandom_range(200, 6000);
            end
            CFG_WILD: begin
                ca  = COEF_W'($urandom);
                cb  = COEF_W'($urandom);
                cc  = COEF_W'($urandom);
                cd  = COEF_W'($urandom);
                amp = int'(SAMPLE_MAX);
            end
            default: begin
                ca  = edge_coef();
                cb  = edge_coef();
                cc  = edge_coef();
                cd  = edge_coef();
                amp = int'(SAMPLE_MAX);
            end
        endcase
        load_filter(mode, ca, cb, cc, cd);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(input int amp);
        int value;
        case ($urandom_range(0, 19))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_WIDTH'($urandom);
            default: begin
                value = int'($urandom_range(0, 2 * amp)) - amp;
                return SAMPLE_WIDTH'(value);
            end
        endcase
    endfunction

    function automatic int gap_length();
        case ($urandom_range(0, 9))
            0, 1, 2:    return 0;
            3, 4, 5, 6: return $urandom_range(1, 6);
            default:    return $urandom_range(10, 130);
        endcase
    endfunction

    initial begin
        int    amp;
        int    burst_left;
        bit    no_gaps;
        t_func func;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_FILTER;
        in_ch.sample_in = '0;
        items_sent      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset coefficients pass samples through unchanged
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, SAMPLE_MIN);
        send_item(FUNC_FILTER, '0);
        send_item(FUNC_FILTER, SAMPLE_WIDTH'(1));
        send_item(FUNC_FILTER, '1);
        send_item(FUNC_CLEAR, SAMPLE_WIDTH'($urandom));
        wait_idle();

        // largest gains clip at both rails, clear drops the history
        load_filter(MODE_ALLPOLE, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, SAMPLE_MIN);
        send_item(FUNC_FILTER, SAMPLE_WIDTH'(100));
        send_item(FUNC_CLEAR, SAMPLE_MAX);
        send_item(FUNC_FILTER, -SAMPLE_WIDTH'(5));
        wait_idle();

        // anti-resonator with opposite corner coefficients
        load_filter(MODE_ANTI, COEF_MIN, COEF_MAX, COEF_MIN, '0);
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, SAMPLE_MIN);
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, '1);
        wait_idle();

        // constant-gain with the strongest negative input lag
        load_filter(MODE_CGAIN, COEF_ONE, to_coef(0.5), to_coef(-0.25), COEF_MIN);
        send_item(FUNC_FILTER, SAMPLE_MIN);
        send_item(FUNC_FILTER, SAMPLE_WIDTH'(12345));
        send_item(FUNC_FILTER, SAMPLE_MAX);
        send_item(FUNC_FILTER, '0);
        wait_idle();

        // unused mode code acts as all-pole, a write past the last register is dropped
        load_filter(MODE_UNUSED, to_coef(0.75), to_coef(1.5), to_coef(-0.8), COEF_MAX);
        write_reg(SEL_W'($urandom_range(NUM_REGS, REG_SLOTS - 1)), $urandom);
        send_item(FUNC_FILTER, SAMPLE_WIDTH'(20000));
        send_item(FUNC_FILTER, SAMPLE_WIDTH'(-20000));
        send_item(FUNC_CLEAR, SAMPLE_MIN);
        send_item(FUNC_FILTER, SAMPLE_WIDTH'(7));
        wait_idle();

        // random filter settings, each followed by a bursty sample stream
        while (items_sent < ITEM_TARGET) begin
            random_filter(amp);
            no_gaps    = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            repeat ($urandom_range(60, 200)) begin
                if (burst_left == 0) begin
                    if (!no_gaps)
                        hold_off(gap_length());
                    burst_left = $urandom_range(1, 16);
                end
                func = ($urandom_range(0, 24) == 0) ? FUNC_CLEAR : FUNC_FILTER;
                send_item(func, pick_sample(amp));
                burst_left--;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
sv/fmr_pkg.sv
sv/fmr_if.sv
sv/fmr_apb_regs.sv
sv/fmr_serial_mac.sv
sv/formant_resonator_filter.sv
dv/formant_resonator_filter_checker.sv
dv/formant_resonator_filter_tb.sv
